>>> rtl/conv2d_valid_mac_defines.svh
// Assertion macros for the convolution block.
// Depends on nothing; the asserting module supplies i_clk and i_rst_n.
`ifndef CONV2D_VALID_MAC_DEFINES_SVH
`define CONV2D_VALID_MAC_DEFINES_SVH

`ifndef SYNTH
// a implies b in the same cycle
`define C2DV_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) else $error(msg);
// a implies b in the next cycle
`define C2DV_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) else $error(msg);
`else
`define C2DV_ASSERT_IMP(lbl, a, b, msg)
`define C2DV_ASSERT_NEXT(lbl, a, b, msg)
`endif

`endif

>>> rtl/c2dv_pkg.sv
// Shared constants, codes and helpers of the convolution block.
// Used by the top level; no dependencies.
package c2dv_pkg;

    localparam int WEIGHT_DEPTH = 8192;
    localparam int BIAS_DEPTH   = 32;
    localparam int ACT_DEPTH    = 16384;
    localparam int DATA_WIDTH   = 16;

    localparam int WEIGHT_AW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int BIAS_AW   = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;

    // full-width address arithmetic, large enough for any register setting
    localparam int ADDR_W    = 24;
    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int ACC_W     = 48;
    localparam int FRAC_BITS = 8;
    localparam int CFG_W     = 7;
    localparam int CNT_W     = 11;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_BIAS   = 2'd1,
        OP_LOAD_ACT    = 2'd2,
        OP_COMPUTE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_IN_CHANNELS  = 3'd0,
        CFG_IN_HEIGHT    = 3'd1,
        CFG_IN_WIDTH     = 3'd2,
        CFG_OUT_CHANNELS = 3'd3,
        CFG_KERNEL_H     = 3'd4,
        CFG_KERNEL_W     = 3'd5,
        CFG_BATCH_COUNT  = 3'd6
    } t_cfg_idx;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/c2dv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c2dv_ram #(
    parameter int P_WIDTH = 16,
    parameter int P_DEPTH = 1024,
    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [P_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [P_WIDTH-1:0] o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/conv2d_valid_mac.sv
// Channel   Direction  Signals
// in        sink       i_in_valid, o_in_stall, i_operation .. i_out_col
// out       source     o_out_valid, i_out_stall, o_conv_value, o_status
// cfg       sink       i_cfg_we, i_cfg_index, i_cfg_data
//
// A load is written, and a bad request posted with its status set, as it is accepted.
// A compute runs from the accepting cycle through two setup states that form the
// addresses, one MAC issue per tap through the single activation and weight read
// ports, a drain of the read/multiply pipe and a final state that saturates the sum.
// Reset clears control state only; the stores need no clearing. Input stalls while a
// compute runs or while a finished word waits in the output register behind a
// stalled output.
//
// Top level of the convolution block: control, address generation and MAC.
// Depends on c2dv_pkg, c2dv_ram and conv2d_valid_mac_defines.svh.
`include "conv2d_valid_mac_defines.svh"

module conv2d_valid_mac
    import c2dv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_operation,
    input  logic [13:0]             i_index,
    input  logic signed [15:0]      i_load_value,
    input  logic [3:0]              i_image_index,
    input  logic [4:0]              i_out_channel,
    input  logic [5:0]              i_out_row,
    input  logic [5:0]              i_out_col,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [31:0]      o_conv_value,
    output logic                    o_status,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETUP1 = 6'b000010,
        S_SETUP2 = 6'b000100,
        S_RUN    = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_FINAL  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [4:0] r_in_channels;
    logic [6:0] r_in_height;
    logic [6:0] r_in_width;
    logic [5:0] r_out_channels;
    logic [2:0] r_kernel_h;
    logic [2:0] r_kernel_w;
    logic [4:0] r_batch_count;

    // request fields
    logic [3:0] r_n;
    logic [4:0] r_oc;
    logic [5:0] r_oh;
    logic [5:0] r_ow;

    // setup products
    logic [8:0]  r_nc;
    logic [13:0] r_plane;
    logic [5:0]  r_taps;
    logic [13:0] r_rowoff;
    logic [9:0]  r_occ;

    // tap walk
    logic [ADDR_W-1:0] r_a_chan, r_a_row, r_a_addr, r_w_addr;
    logic [CNT_W-1:0]  r_total, r_cnt;
    logic [2:0]        r_kw, r_kh;

    // read and multiply pipe
    logic                     r_rd_vld, r_rd_aok, r_rd_wok;
    logic                     r_mul_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic              r_out_valid, r_status;
    logic signed [31:0] r_conv;

    logic                  in_acc, out_free, is_bad, issue, a_ok, w_ok;
    logic [ADDR_W-1:0]     index_ext;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] act_q, wgt_q, bias_q;
    logic signed [DATA_WIDTH-1:0] act_s, wgt_s;
    logic [6:0]            row_end, col_end;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign row_end = 7'(i_out_row) + 7'(r_kernel_h);
    assign col_end = 7'(i_out_col) + 7'(r_kernel_w);
    assign is_bad  = (5'(i_image_index) >= r_batch_count)
                  || (6'(i_out_channel) >= r_out_channels)
                  || (row_end > r_in_height)
                  || (col_end > r_in_width);

    assign index_ext = ADDR_W'(i_index);
    assign wdata     = DATA_WIDTH'($unsigned(i_load_value));

    assign a_ok  = r_a_addr < ADDR_W'(ACT_DEPTH);
    assign w_ok  = r_w_addr < ADDR_W'(WEIGHT_DEPTH);
    assign issue = (r_state == S_RUN) && (r_cnt != r_total);

    c2dv_ram #(.P_WIDTH(DATA_WIDTH), .P_DEPTH(WEIGHT_DEPTH)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_operation == OP_LOAD_WEIGHT)
                  && (index_ext < ADDR_W'(WEIGHT_DEPTH))),
        .i_waddr (index_ext[WEIGHT_AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_w_addr[WEIGHT_AW-1:0]),
        .o_rdata (wgt_q)
    );

    c2dv_ram #(.P_WIDTH(DATA_WIDTH), .P_DEPTH(BIAS_DEPTH)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_operation == OP_LOAD_BIAS)
                  && (index_ext < ADDR_W'(BIAS_DEPTH))),
        .i_waddr (index_ext[BIAS_AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (BIAS_AW'(r_oc)),
        .o_rdata (bias_q)
    );

    c2dv_ram #(.P_WIDTH(DATA_WIDTH), .P_DEPTH(ACT_DEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_operation == OP_LOAD_ACT)
                  && (index_ext < ADDR_W'(ACT_DEPTH))),
        .i_waddr (index_ext[ACT_AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_a_addr[ACT_AW-1:0]),
        .o_rdata (act_q)
    );

    // out-of-depth addresses read as zero
    assign act_s = r_rd_aok ? $signed(act_q) : '0;
    assign wgt_s = r_rd_wok ? $signed(wgt_q) : '0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation == OP_COMPUTE) && !is_bad) begin
                    n_state = S_SETUP1;
                end
            end
            S_SETUP1: n_state = S_SETUP2;
            S_SETUP2: n_state = S_RUN;
            S_RUN: begin
                if (r_cnt == r_total) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !r_mul_vld) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_in_channels  <= 5'd1;
            r_in_height    <= 7'd28;
            r_in_width     <= 7'd28;
            r_out_channels <= 6'd10;
            r_kernel_h     <= 3'd5;
            r_kernel_w     <= 3'd5;
            r_batch_count  <= 5'd1;
            r_rd_vld       <= 1'b0;
            r_mul_vld      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= issue;
            r_mul_vld <= r_rd_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IN_CHANNELS:  r_in_channels  <= i_cfg_data[4:0];
                    CFG_IN_HEIGHT:    r_in_height    <= i_cfg_data[6:0];
                    CFG_IN_WIDTH:     r_in_width     <= i_cfg_data[6:0];
                    CFG_OUT_CHANNELS: r_out_channels <= i_cfg_data[5:0];
                    CFG_KERNEL_H:     r_kernel_h     <= i_cfg_data[2:0];
                    CFG_KERNEL_W:     r_kernel_w     <= i_cfg_data[2:0];
                    CFG_BATCH_COUNT:  r_batch_count  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            priority if ((r_state == S_FINAL) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (in_acc && (i_operation == OP_COMPUTE) && is_bad) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_n  <= i_image_index;
            r_oc <= i_out_channel;
            r_oh <= i_out_row;
            r_ow <= i_out_col;
        end

        if (r_state == S_SETUP1) begin
            r_nc     <= 9'(r_n) * 9'(r_in_channels);
            r_plane  <= 14'(r_in_height) * 14'(r_in_width);
            r_taps   <= 6'(r_kernel_h) * 6'(r_kernel_w);
            r_rowoff <= 14'(r_oh) * 14'(r_in_width) + 14'(r_ow);
            r_occ    <= 10'(r_oc) * 10'(r_in_channels);
        end

        if (r_state == S_SETUP2) begin
            r_a_chan <= ADDR_W'(r_nc) * ADDR_W'(r_plane) + ADDR_W'(r_rowoff);
            r_a_row  <= ADDR_W'(r_nc) * ADDR_W'(r_plane) + ADDR_W'(r_rowoff);
            r_a_addr <= ADDR_W'(r_nc) * ADDR_W'(r_plane) + ADDR_W'(r_rowoff);
            r_w_addr <= ADDR_W'(r_occ) * ADDR_W'(r_taps);
            r_total  <= CNT_W'(r_in_channels) * CNT_W'(r_taps);
            r_cnt    <= '0;
            r_kw     <= '0;
            r_kh     <= '0;
            // accumulator starts at the bias aligned to product scale
            if (32'(r_oc) < BIAS_DEPTH) begin
                r_acc <= ACC_W'($signed(bias_q)) <<< FRAC_BITS;
            end else begin
                r_acc <= '0;
            end
        end else if (r_mul_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end

        if (issue) begin
            r_rd_aok <= a_ok;
            r_rd_wok <= w_ok;
            r_cnt    <= r_cnt + 1'b1;
            r_w_addr <= r_w_addr + 1'b1;
            if (4'(r_kw) + 4'd1 == 4'(r_kernel_w)) begin
                r_kw <= '0;
                if (4'(r_kh) + 4'd1 == 4'(r_kernel_h)) begin
                    // next input channel plane
                    r_kh     <= '0;
                    r_a_chan <= r_a_chan + ADDR_W'(r_plane);
                    r_a_row  <= r_a_chan + ADDR_W'(r_plane);
                    r_a_addr <= r_a_chan + ADDR_W'(r_plane);
                end else begin
                    r_kh     <= r_kh + 1'b1;
                    r_a_row  <= r_a_row + ADDR_W'(r_in_width);
                    r_a_addr <= r_a_row + ADDR_W'(r_in_width);
                end
            end else begin
                r_kw     <= r_kw + 1'b1;
                r_a_addr <= r_a_addr + 1'b1;
            end
        end

        r_prod <= act_s * wgt_s;

        priority if ((r_state == S_FINAL) && out_free) begin
            r_conv   <= sat32(r_acc);
            r_status <= 1'b0;
        end else if (in_acc && (i_operation == OP_COMPUTE) && is_bad) begin
            r_conv   <= '0;
            r_status <= 1'b1;
        end else begin
            // hold the posted word
            r_conv   <= r_conv;
            r_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_conv_value = r_conv;
    assign o_status     = r_status;

    `C2DV_ASSERT_NEXT(a_start, (r_state == S_IDLE) && in_acc && (i_operation == OP_COMPUTE) && !is_bad, r_state == S_SETUP1, "good compute did not start setup")
    `C2DV_ASSERT_IMP(a_cnt_bound, r_state == S_RUN, r_cnt <= r_total, "tap count ran past total")
    `C2DV_ASSERT_IMP(a_final_empty, r_state == S_FINAL, !r_rd_vld && !r_mul_vld, "result taken with MAC pipe busy")
    `C2DV_ASSERT_NEXT(a_final_out, (r_state == S_FINAL) && out_free, r_out_valid && (r_state == S_IDLE), "finished word not posted")

endmodule

>>> tb/sv/conv2d_valid_mac_tb.sv
// Self-checking bench for conv2d_valid_mac: load and compute words go in, and a scoreboard
// class predicts every convolution point and checks each result word in order.
// Depends on c2dv_pkg and the conv2d_valid_mac RTL.
module conv2d_valid_mac_tb
    import c2dv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 10;
    localparam longint Q16_MAX    = 64'sd2147483647;
    localparam longint Q16_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
    } t_conv_point;

    class t_conv_checker;
        logic [DATA_WIDTH-1:0] weights [WEIGHT_DEPTH];
        logic [DATA_WIDTH-1:0] biases  [BIAS_DEPTH];
        logic [DATA_WIDTH-1:0] acts    [ACT_DEPTH];
        int unsigned n_ch, height, width, n_oc, k_h, k_w, n_img;
        t_conv_point expected_points[$];
        int failures;

        function new();
            n_ch = 1;
            height = 28;
            width = 28;
            n_oc = 10;
            k_h = 5;
            k_w = 5;
            n_img = 1;
            failures = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_IN_CHANNELS:  n_ch   = data[4:0];
                CFG_IN_HEIGHT:    height = data[6:0];
                CFG_IN_WIDTH:     width  = data[6:0];
                CFG_OUT_CHANNELS: n_oc   = data[5:0];
                CFG_KERNEL_H:     k_h    = data[2:0];
                CFG_KERNEL_W:     k_w    = data[2:0];
                CFG_BATCH_COUNT:  n_img  = data[4:0];
                default: ;
            endcase
        endfunction

        function bit in_extent(int unsigned img, int unsigned oc, int unsigned row,
                               int unsigned col);
            return img < n_img && oc < n_oc && row + k_h <= height && col + k_w <= width;
        endfunction

        function t_conv_point conv_point(int unsigned img, int unsigned oc,
                                         int unsigned row, int unsigned col);
            t_conv_point pt;
            logic [ACC_W-1:0] acc;
            longint a_addr, w_addr, a_val, w_val, total;
            pt.value = '0;
            pt.status = 1'b1;
            if (!in_extent(img, oc, row, col)) begin
                return pt;
            end
            total = (oc < BIAS_DEPTH) ? longint'($signed(biases[oc])) : 64'sd0;
            acc = ACC_W'(total <<< FRAC_BITS);
            for (int unsigned ic = 0; ic < n_ch; ic++) begin
                for (int unsigned kh = 0; kh < k_h; kh++) begin
                    for (int unsigned kw = 0; kw < k_w; kw++) begin
                        a_addr = ((longint'(img) * n_ch + ic) * height + row + kh) * width
                                 + col + kw;
                        w_addr = ((longint'(oc) * n_ch + ic) * k_h + kh) * k_w + kw;
                        // addresses past the end of a store read as zero
                        a_val = (a_addr < ACT_DEPTH) ? longint'($signed(acts[a_addr])) : 0;
                        w_val = (w_addr < WEIGHT_DEPTH) ?
                                longint'($signed(weights[w_addr])) : 0;
                        acc = acc + ACC_W'(a_val * w_val);
                    end
                end
            end
            total = longint'($signed(acc));
            if (total > Q16_MAX) begin
                total = Q16_MAX;
            end else if (total < Q16_MIN) begin
                total = Q16_MIN;
            end
            pt.value = 32'(total);
            pt.status = 1'b0;
            return pt;
        endfunction

        function void note_word(t_op op, logic [13:0] idx, logic [15:0] word,
                                logic [3:0] img, logic [4:0] oc, logic [5:0] row,
                                logic [5:0] col);
            case (op)
                OP_LOAD_WEIGHT: if (idx < WEIGHT_DEPTH) weights[idx] = word;
                OP_LOAD_BIAS:   if (idx < BIAS_DEPTH) biases[idx] = word;
                OP_LOAD_ACT:    if (idx < ACT_DEPTH) acts[idx] = word;
                default:        expected_points.push_back(conv_point(img, oc, row, col));
            endcase
        endfunction

        function void check_point(logic signed [31:0] value, logic status);
            t_conv_point want;
            if (expected_points.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result word: value=%0d status=%0b",
                             value, status);
                end
                return;
            end
            want = expected_points.pop_front();
            if (value !== want.value || status !== want.status) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("ERROR: conv_value exp %0d got %0d, status exp %0b got %0b",
                             want.value, value, want.status, status);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = '0;
    logic [13:0]        index = '0;
    logic signed [15:0] load_value = '0;
    logic [3:0]         image_index = '0;
    logic [4:0]         out_channel = '0;
    logic [5:0]         out_row = '0;
    logic [5:0]         out_col = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] conv_value;
    logic               status;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    bit act_seen  [ACT_DEPTH];
    bit wgt_seen  [WEIGHT_DEPTH];
    bit bias_seen [BIAS_DEPTH];
    t_conv_checker book = new();

    conv2d_valid_mac DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_index       (index),
        .i_load_value  (load_value),
        .i_image_index (image_index),
        .i_out_channel (out_channel),
        .i_out_row     (out_row),
        .i_out_col     (out_col),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_conv_value  (conv_value),
        .o_status      (status),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            book.check_point(conv_value, status);
        end
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [15:0] random_word();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(t_op op, logic [13:0] idx, logic [15:0] word, logic [3:0] img,
                             logic [4:0] oc, logic [5:0] row, logic [5:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        operation   <= op;
        index       <= idx;
        load_value  <= word;
        image_index <= img;
        out_channel <= oc;
        out_row     <= row;
        out_col     <= col;
        do @(posedge clk); while (in_stall);
        book.note_word(op, idx, word, img, oc, row, col);
    endtask

    task automatic send_load(t_op op, logic [13:0] idx, logic [15:0] word);
        case (op)
            OP_LOAD_WEIGHT: if (idx < WEIGHT_DEPTH) wgt_seen[idx] = 1'b1;
            OP_LOAD_BIAS:   if (idx < BIAS_DEPTH) bias_seen[idx] = 1'b1;
            OP_LOAD_ACT:    if (idx < ACT_DEPTH) act_seen[idx] = 1'b1;
            default: ;
        endcase
        // compute fields are don't-care on a load: toggle them anyway
        send_word(op, idx, word, 4'($urandom), 5'($urandom), 6'($urandom), 6'($urandom));
    endtask

    // Load every store entry the point reads that was never written, then request it.
    task automatic compute_point(int unsigned img, int unsigned oc, int unsigned row,
                                 int unsigned col);
        longint a_addr, w_addr;
        if (book.in_extent(img, oc, row, col)) begin
            if (oc < BIAS_DEPTH && !bias_seen[oc]) begin
                send_load(OP_LOAD_BIAS, 14'(oc), random_word());
            end
            for (int unsigned ic = 0; ic < book.n_ch; ic++) begin
                for (int unsigned kh = 0; kh < book.k_h; kh++) begin
                    for (int unsigned kw = 0; kw < book.k_w; kw++) begin
                        a_addr = ((longint'(img) * book.n_ch + ic) * book.height + row + kh)
                                 * book.width + col + kw;
                        w_addr = ((longint'(oc) * book.n_ch + ic) * book.k_h + kh)
                                 * book.k_w + kw;
                        if (a_addr < ACT_DEPTH && !act_seen[a_addr]) begin
                            send_load(OP_LOAD_ACT, 14'(a_addr), random_word());
                        end
                        if (w_addr < WEIGHT_DEPTH && !wgt_seen[w_addr]) begin
                            send_load(OP_LOAD_WEIGHT, 14'(w_addr), random_word());
                        end
                    end
                end
            end
        end
        send_word(OP_COMPUTE, 14'($urandom), 16'($urandom), 4'(img), 5'(oc), 6'(row),
                  6'(col));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.expected_points.size() != 0) @(posedge clk);
        // loads give no result word: give the block time to finish the last one
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(data);
        @(posedge clk);
        book.set_reg(idx, CFG_W'(data));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int unsigned ic, int unsigned h, int unsigned w,
                              int unsigned oc, int unsigned kh, int unsigned kw,
                              int unsigned n, int mode);
        settle();
        write_reg(CFG_IN_CHANNELS, ic);
        write_reg(CFG_IN_HEIGHT, h);
        write_reg(CFG_IN_WIDTH, w);
        write_reg(CFG_OUT_CHANNELS, oc);
        write_reg(CFG_KERNEL_H, kh);
        write_reg(CFG_KERNEL_W, kw);
        write_reg(CFG_BATCH_COUNT, n);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    task automatic run_random(int count);
        int unsigned act_span, wgt_span, bias_span, r;
        int unsigned img_max, oc_max, row_max, col_max;
        act_span = book.n_img * book.n_ch * book.height * book.width;
        act_span = (act_span > ACT_DEPTH) ? ACT_DEPTH : (act_span == 0) ? 1 : act_span;
        wgt_span = book.n_oc * book.n_ch * book.k_h * book.k_w;
        wgt_span = (wgt_span > WEIGHT_DEPTH) ? WEIGHT_DEPTH : (wgt_span == 0) ? 1 : wgt_span;
        bias_span = (book.n_oc > BIAS_DEPTH) ? BIAS_DEPTH : (book.n_oc == 0) ? 1 : book.n_oc;
        img_max = (book.n_img > 16) ? 15 : book.n_img - 1;
        oc_max = (book.n_oc > 32) ? 31 : book.n_oc - 1;
        row_max = (book.height - book.k_h > 63) ? 63 : book.height - book.k_h;
        col_max = (book.width - book.k_w > 63) ? 63 : book.width - book.k_w;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 30) begin
                send_load(OP_LOAD_ACT, 14'($urandom_range(act_span - 1)), random_word());
            end else if (r < 45) begin
                send_load(OP_LOAD_WEIGHT, 14'($urandom_range(wgt_span - 1)), random_word());
            end else if (r < 50) begin
                send_load(OP_LOAD_BIAS, 14'($urandom_range(bias_span - 1)), random_word());
            end else if (r < 55) begin
                send_load(t_op'($urandom_range(2)), 14'($urandom), random_word());
            end else if (r < 85 && book.n_img > 0 && book.n_oc > 0 &&
                         book.height >= book.k_h && book.width >= book.k_w) begin
                compute_point($urandom_range(img_max), $urandom_range(oc_max),
                              $urandom_range(row_max), $urandom_range(col_max));
            end else begin
                compute_point($urandom_range(15), $urandom_range(31), $urandom_range(63),
                              $urandom_range(63));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // four channels of one pixel, 1x1 kernel: each point sums four products
        set_config(4, 1, 1, 2, 1, 1, 1, 0);
        for (int i = 0; i < 4; i++) begin
            send_load(OP_LOAD_ACT, 14'(i), 16'h8000);
            send_load(OP_LOAD_WEIGHT, 14'(i), 16'h8000);
            send_load(OP_LOAD_WEIGHT, 14'(4 + i), (i == 0) ? 16'h7FFF : 16'h0000);
        end
        send_load(OP_LOAD_BIAS, 14'd0, 16'h7FFF);
        send_load(OP_LOAD_BIAS, 14'd1, 16'h8000);
        compute_point(0, 0, 0, 0);
        compute_point(0, 1, 0, 0);
        // drop out-of-depth loads; an aliased write would change channel one
        send_load(OP_LOAD_WEIGHT, 14'(WEIGHT_DEPTH + 4), 16'h8000);
        send_load(OP_LOAD_BIAS, 14'(BIAS_DEPTH + 1), 16'h7FFF);
        compute_point(0, 1, 0, 0);
        for (int i = 1; i < 4; i++) begin
            send_load(OP_LOAD_WEIGHT, 14'(4 + i), 16'h7FFF);
        end
        compute_point(0, 1, 0, 0);
        compute_point(1, 0, 0, 0);
        compute_point(0, 2, 0, 0);
        compute_point(0, 0, 1, 0);
        compute_point(0, 0, 0, 1);

        set_config(1, 1, 1, 1, 1, 1, 1, 1);
        run_random(60);
        for (int p = 0; p < 5; p++) begin
            set_config($urandom_range(1, 3), $urandom_range(1, 8), $urandom_range(1, 8),
                       $urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3),
                       $urandom_range(1, 3), p + 2);
            run_random(70);
        end

        // masked writes: zero channels, zero kernel rows, oversized extents
        set_config(7'h20, 7'h7F, 7'h7F, 7'h7F, 7'h78, 7'h7F, 7'h50, 3);
        run_random(40);

        // large sizes: activations and weights both run past the end of their stores
        set_config(16, 64, 64, 32, 7, 7, 16, 3);
        compute_point(0, 10, 57, 57);
        compute_point(15, 31, 57, 57);
        compute_point(0, 0, 58, 0);
        compute_point(0, 0, 0, 58);

        settle();
        if (book.failures == 0 && book.expected_points.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
